// ----- sv/spq_pkg.sv -----
// Package with shared types, field widths and codes for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 8;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REMOVED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] value;
        logic        [RANK_W-1:0]  rank;
    } t_cell_ctrl;

endpackage

// ----- sv/spq_if.sv -----
// Request and response channel interfaces of the stable priority queue.
`timescale 1ns / 1ps

interface spq_req_if import spq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [VALUE_W-1:0] item_value;
    logic        [RANK_W-1:0]  item_rank;

    modport source (output valid, req_type, item_value, item_rank, input ready);
    modport sink   (input valid, req_type, item_value, item_rank, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [STAT_W-1:0]  status;
    logic signed [VALUE_W-1:0] out_value;
    logic        [RANK_W-1:0]  out_rank;
    logic        [OCC_W-1:0]   occupancy;

    modport source (output valid, status, out_value, out_rank, occupancy, input ready);
    modport sink   (input valid, status, out_value, out_rank, occupancy, output ready);
endinterface

// ----- sv/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic                      i_valid,
    input  logic                      i_prev_keep,
    input  logic signed [VALUE_W-1:0] i_prev_value,
    input  logic        [RANK_W-1:0]  i_prev_rank,
    input  logic signed [VALUE_W-1:0] i_next_value,
    input  logic        [RANK_W-1:0]  i_next_rank,
    output logic                      o_keep,
    output logic signed [VALUE_W-1:0] o_value,
    output logic        [RANK_W-1:0]  o_rank
);

    logic signed [VALUE_W-1:0] r_value;
    logic        [RANK_W-1:0]  r_rank;

    // A held entry of equal or higher priority stays ahead of the new one.
    assign o_keep  = i_valid && (r_rank >= i_ctrl.rank);
    assign o_value = r_value;
    assign o_rank  = r_rank;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && !o_keep) begin
            if (i_prev_keep) begin
                r_value <= i_ctrl.value;
                r_rank  <= i_ctrl.rank;
            end else begin
                r_value <= i_prev_value;
                r_rank  <= i_prev_rank;
            end
        end else if (i_ctrl.rem) begin
            r_value <= i_next_value;
            r_rank  <= i_next_rank;
        end
    end

endmodule

// ----- sv/stable_priority_queue_top.sv -----
// Top level of the stable priority queue: request handling, cell chain and result register.
`timescale 1ns / 1ps

// A sorted chain of CAPACITY cells holds the entries, front first. Every cell compares
// its priority with an incoming insert in parallel and either holds, takes the new word
// or takes its front neighbor's word, so an insert or a remove completes with no
// search. A request is taken whenever the result register is free or being emptied
// in the same cycle; its result appears in that register in the cycle after
// acceptance, giving one request per cycle under a ready sink. Entries of equal
// priority leave in arrival order; an insert into a full queue is dropped with status
// full, and a remove on an empty queue returns zeros with status empty.
module stable_priority_queue_top import spq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [OCC_W-1:0]  r_occ;

    logic       accept, is_ins, full, empty;
    t_cell_ctrl ctrl;

    logic                      keep   [CAPACITY];
    logic signed [VALUE_W-1:0] cvalue [CAPACITY];
    logic        [RANK_W-1:0]  crank  [CAPACITY];
    logic [CNT_W+OCC_W-1:0]    occ_wide;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_ins      = (i_req.req_type == REQ_INSERT);
    assign full        = (r_count == CNT_W'(CAPACITY));
    assign empty       = (r_count == '0);

    assign ctrl.ins   = accept && is_ins && !full;
    assign ctrl.rem   = accept && !is_ins && !empty;
    assign ctrl.value = i_req.item_value;
    assign ctrl.rank  = i_req.item_rank;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                      prev_keep;
            logic signed [VALUE_W-1:0] prev_value, next_value;
            logic        [RANK_W-1:0]  prev_rank, next_rank;

            if (g == 0) begin : g_front
                assign prev_keep  = 1'b1;
                assign prev_value = '0;
                assign prev_rank  = '0;
            end else begin : g_inner
                assign prev_keep  = keep[g-1];
                assign prev_value = cvalue[g-1];
                assign prev_rank  = crank[g-1];
            end
            if (g == CAPACITY - 1) begin : g_back
                assign next_value = '0;
                assign next_rank  = '0;
            end else begin : g_body
                assign next_value = cvalue[g+1];
                assign next_rank  = crank[g+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_valid      (CNT_W'(g) < r_count),
                .i_prev_keep  (prev_keep),
                .i_prev_value (prev_value),
                .i_prev_rank  (prev_rank),
                .i_next_value (next_value),
                .i_next_rank  (next_rank),
                .o_keep       (keep[g]),
                .o_value      (cvalue[g]),
                .o_rank       (crank[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = STAT_INSERTED;
        n_value  = '0;
        n_rank   = '0;
        if (is_ins) begin
            if (full) begin
                n_status = STAT_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_status = STAT_EMPTY;
            end else begin
                n_status = STAT_REMOVED;
                n_value  = cvalue[0];
                n_rank   = crank[0];
                n_count  = r_count - 1'b1;
            end
        end
    end

    // The occupancy field carries the low bits of the count.
    assign occ_wide = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_rank   <= n_rank;
            r_occ    <= occ_wide[OCC_W-1:0];
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.out_value = r_value;
    assign o_rsp.out_rank  = r_rank;
    assign o_rsp.occupancy = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_ins && !full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the count");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request gave no result");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_ins && empty) |=> (r_status == STAT_EMPTY && r_count == '0))
        else $error("remove on empty queue misreported");

endmodule

// ----- tb/stable_priority_queue_top_tb.sv -----
// Self-checking testbench of the stable priority queue with a shadow queue scoreboard.
`timescale 1ns / 1ps

module stable_priority_queue_top_tb;

    import spq_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [RANK_W-1:0]  rank;
    } t_held_entry;

    typedef struct packed {
        logic        [STAT_W-1:0]  status;
        logic signed [VALUE_W-1:0] value;
        logic        [RANK_W-1:0]  rank;
        logic        [OCC_W-1:0]   occupancy;
    } t_result_word;

    // Keeps its own sorted copy of the queue and the results still to come.
    class queue_shadow;
        t_held_entry  held_entries[$];
        t_result_word awaited_results[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void note_request(input logic kind,
                                   input logic signed [VALUE_W-1:0] value,
                                   input logic [RANK_W-1:0] rank);
            t_result_word res;
            t_held_entry  entry;
            int           pos;
            res.status = STAT_INSERTED;
            res.value  = '0;
            res.rank   = '0;
            if (kind == REQ_INSERT) begin
                if (held_entries.size() >= CAPACITY_DEF) begin
                    res.status = STAT_FULL;
                end else begin
                    // An entry goes behind every held entry of equal or greater priority.
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].rank >= rank)
                        pos++;
                    entry.value = value;
                    entry.rank  = rank;
                    held_entries.insert(pos, entry);
                end
            end else if (held_entries.size() == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                entry      = held_entries.pop_front();
                res.status = STAT_REMOVED;
                res.value  = entry.value;
                res.rank   = entry.rank;
            end
            res.occupancy = OCC_W'(held_entries.size());
            awaited_results.push_back(res);
        endfunction

        function void check_result(input t_result_word got);
            t_result_word want;
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result word status=%0d value=%0d rank=%0d occ=%0d",
                             $realtime, got.status, got.value, got.rank, got.occupancy);
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.value !== want.value ||
                got.rank !== want.rank || got.occupancy !== want.occupancy) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: mismatch expected status=%0d value=%0d rank=%0d occ=%0d,",
                             $realtime, want.status, want.value, want.rank, want.occupancy,
                             " got status=%0d value=%0d rank=%0d occ=%0d",
                             got.status, got.value, got.rank, got.occupancy);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    int sender_idle_pct;
    int sink_stall_pct;

    queue_shadow shadow = new();

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    stable_priority_queue_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: ready changes at the falling edge.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            shadow.check_result('{rsp_if.status, rsp_if.out_value, rsp_if.out_rank,
                                  rsp_if.occupancy});
    end

    // Entered and left at a falling edge; valid stays high between back-to-back words.
    task automatic send_request(input logic kind,
                                input logic signed [VALUE_W-1:0] value,
                                input logic [RANK_W-1:0] rank);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.item_value <= value;
        req_if.item_rank  <= rank;
        do @(posedge i_clk); while (!req_if.ready);
        shadow.note_request(kind, value, rank);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (shadow.pending() != 0);
    endtask

    // Segments lean toward inserts or removes so the queue swings between full and empty.
    task automatic random_requests(input int count);
        int                 left;
        int                 seg_left;
        int                 insert_pct;
        logic               kind;
        logic [RANK_W-1:0]  rank;
        seg_left   = 0;
        insert_pct = 50;
        for (left = count; left > 0; left--) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            seg_left--;
            kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
            // Mostly a few priorities, so that ties are common.
            case ($urandom_range(0, 9))
                0:       rank = '0;
                1:       rank = '1;
                2, 3, 4: rank = RANK_W'($urandom_range(0, 255));
                default: rank = RANK_W'($urandom_range(0, 3));
            endcase
            send_request(kind, $urandom, rank);
        end
    endtask

    initial begin
        int i;
        int phase;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_INSERT;
        req_if.item_value = '0;
        req_if.item_rank  = '0;
        sender_idle_pct   = 0;
        sink_stall_pct    = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: remove on empty, extremes, ties, fill to full, drop, partial drain.
        send_request(REQ_REMOVE, '0, '0);
        send_request(REQ_INSERT, 32'sh7fffffff, 8'd0);
        send_request(REQ_INSERT, 32'sh80000000, 8'd255);
        send_request(REQ_INSERT, -32'sd1, 8'd128);
        send_request(REQ_INSERT, 32'sd0, 8'd128);
        send_request(REQ_INSERT, 32'sd1, 8'd128);
        for (i = 5; i < CAPACITY_DEF; i++)
            send_request(REQ_INSERT, $urandom,
                         (i % 3 == 0) ? 8'd0 : ((i % 3 == 1) ? 8'd255 : 8'd128));
        send_request(REQ_INSERT, 32'sh5a5a5a5a, 8'd255);
        for (i = 0; i < 5; i++)
            send_request(REQ_REMOVE, $urandom, RANK_W'($urandom_range(0, 255)));
        hold_until_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin sender_idle_pct = 74; sink_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin sender_idle_pct = 6;  sink_stall_pct = 6;  end
            endcase
            random_requests(382);
            hold_until_drained();
        end

        repeat (4) @(posedge i_clk);
        if (shadow.mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- stable_priority_queue_top.f -----
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_cell.sv
sv/stable_priority_queue_top.sv
tb/stable_priority_queue_top_tb.sv
